// File: rtl/core/tct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

  localparam int DEF_NUM_CHANNELS = 16;
  localparam int FUNC_W           = 3;
  localparam int KEY_W            = 32;
  localparam int ID_W             = 5;
  localparam int LIMIT_W          = 32;
  localparam int FIRE_W           = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_REGISTER       = 3'd0,
    FUNC_UNREGISTER     = 3'd1,
    FUNC_RESET_COUNTER  = 3'd2,
    FUNC_CHANGE_TIMEOUT = 3'd3,
    FUNC_TICK           = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sweep_req;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/timeout_channel_table_unit.sv
// Register and tick walk every slot of the table, one slot per cycle, before the result
//   strobe; the other operations (unregister, reset counter, change timeout) skip the walk.
//   Start is taken only in idle, while busy is low: a new operation is not accepted until
//   the controller is back in idle after the previous one.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the table and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none

module timeout_channel_table_unit
  import tct_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [KEY_W-1:0]   in_name_key,
  input  wire logic [ID_W-1:0]    in_handler_id,
  input  wire logic [LIMIT_W-1:0] in_timeout_value,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic [ID_W-1:0]         out_id,
  output logic [FIRE_W-1:0]       out_fire_mask
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] rd_addr;

  tct_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  tct_dp #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_name_key      (in_name_key),
    .in_handler_id    (in_handler_id),
    .in_timeout_value (in_timeout_value),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .status           (status),
    .out_ok           (out_ok),
    .out_id           (out_id),
    .out_fire_mask    (out_fire_mask)
  );

endmodule

`default_nettype wire

// File: rtl/core/tct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tct_ctrl
  import tct_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      out_valid,
  input  wire status_t              status,
  output cmd_t                      cmd,
  output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    busy          = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = status.sweep_req ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (32'(cnt_r) < NUM_CHANNELS) begin
          cmd.rd_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr   = IDX_W'(cnt_r);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/tct_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tct_dp
  import tct_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [KEY_W-1:0]     in_name_key,
  input  wire logic [ID_W-1:0]      in_handler_id,
  input  wire logic [LIMIT_W-1:0]   in_timeout_value,
  input  wire cmd_t                 cmd,
  input  wire logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr,
  output status_t                   status,
  output logic                      out_ok,
  output logic [ID_W-1:0]           out_id,
  output logic [FIRE_W-1:0]         out_fire_mask
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [KEY_W-1:0]   key_mem   [NUM_CHANNELS];
  logic [LIMIT_W-1:0] limit_mem [NUM_CHANNELS];
  logic [LIMIT_W-1:0] count_mem [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] active_r, active_nxt;

  logic [FUNC_W-1:0]  func_r;
  logic [KEY_W-1:0]   key_r;
  logic [ID_W-1:0]    hid_r;
  logic [LIMIT_W-1:0] limit_r;

  logic               vd_r;
  logic [IDX_W-1:0]   idx_d_r;
  logic [KEY_W-1:0]   key_q_r;
  logic [LIMIT_W-1:0] limit_q_r;
  logic [LIMIT_W-1:0] count_q_r;

  logic               dup_r, dup_nxt;
  logic [IDX_W-1:0]   dup_idx_r, dup_idx_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [FIRE_W-1:0]  fire_r, fire_nxt;

  logic               ok_r, ok_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [FIRE_W-1:0]  mask_r, mask_nxt;

  logic               key_we;
  logic               limit_we;
  logic               count_we;
  logic [IDX_W-1:0]   key_wa;
  logic [IDX_W-1:0]   limit_wa;
  logic [IDX_W-1:0]   count_wa;
  logic [LIMIT_W-1:0] limit_wd;
  logic [LIMIT_W-1:0] count_wd;

  logic               hid_in_range;
  logic [IDX_W-1:0]   hid_idx;
  logic               hid_hit;
  logic [IDX_W:0]     dup_id_w;
  logic [IDX_W:0]     free_id_w;

  assign status.sweep_req = (in_func == FUNC_REGISTER) || (in_func == FUNC_TICK);

  assign hid_in_range = (hid_r != '0) && (32'(hid_r) <= NUM_CHANNELS);
  assign hid_idx      = IDX_W'(hid_r - ID_W'(1));
  assign hid_hit      = hid_in_range && active_r[hid_idx];
  assign dup_id_w     = {1'b0, dup_idx_r} + (IDX_W+1)'(1);
  assign free_id_w    = {1'b0, free_idx_r} + (IDX_W+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      key_r   <= in_name_key;
      hid_r   <= in_handler_id;
      limit_r <= in_timeout_value;
    end
    if (cmd.rd_en) begin
      idx_d_r   <= rd_addr;
      key_q_r   <= key_mem[rd_addr];
      limit_q_r <= limit_mem[rd_addr];
      count_q_r <= count_mem[rd_addr];
    end
    if (key_we) begin
      key_mem[key_wa] <= key_r;
    end
    if (limit_we) begin
      limit_mem[limit_wa] <= limit_wd;
    end
    if (count_we) begin
      count_mem[count_wa] <= count_wd;
    end
    dup_r      <= dup_nxt;
    dup_idx_r  <= dup_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    fire_r     <= fire_nxt;
    ok_r       <= ok_nxt;
    id_r       <= id_nxt;
    mask_r     <= mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      vd_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      vd_r     <= cmd.rd_en;
    end
  end

  always_comb begin
    active_nxt   = active_r;
    dup_nxt      = dup_r;
    dup_idx_nxt  = dup_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    fire_nxt     = fire_r;
    ok_nxt       = ok_r;
    id_nxt       = id_r;
    mask_nxt     = mask_r;
    key_we       = 1'b0;
    limit_we     = 1'b0;
    count_we     = 1'b0;
    key_wa       = idx_d_r;
    limit_wa     = idx_d_r;
    count_wa     = idx_d_r;
    limit_wd     = limit_r;
    count_wd     = '0;

    if (cmd.load) begin
      dup_nxt  = 1'b0;
      free_nxt = 1'b0;
      fire_nxt = '0;
    end

    // scan stage: one slot per cycle
    if (vd_r) begin
      if (func_r == FUNC_TICK) begin
        if (active_r[idx_d_r]) begin
          count_we = 1'b1;
          if (count_q_r >= limit_q_r) begin
            count_wd = '0;
            for (int b = 0; b < FIRE_W; b++) begin
              if (32'(idx_d_r) == b) begin
                fire_nxt[b] = 1'b1;
              end
            end
          end else begin
            count_wd = count_q_r + LIMIT_W'(1);
          end
        end
      end else begin
        if (active_r[idx_d_r] && (key_q_r == key_r) && !dup_r) begin
          dup_nxt     = 1'b1;
          dup_idx_nxt = idx_d_r;
        end
        if (!active_r[idx_d_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_d_r;
        end
      end
    end

    if (cmd.finish) begin
      ok_nxt   = 1'b0;
      id_nxt   = '0;
      mask_nxt = '0;
      unique case (func_r)
        FUNC_REGISTER: begin
          if (dup_r) begin
            id_nxt = ID_W'(dup_id_w);
          end else if (free_r) begin
            key_we               = 1'b1;
            key_wa               = free_idx_r;
            limit_we             = 1'b1;
            limit_wa             = free_idx_r;
            limit_wd             = limit_r;
            count_we             = 1'b1;
            count_wa             = free_idx_r;
            count_wd             = '0;
            active_nxt[free_idx_r] = 1'b1;
            ok_nxt               = 1'b1;
            id_nxt               = ID_W'(free_id_w);
          end
        end
        FUNC_UNREGISTER: begin
          if (hid_hit) begin
            active_nxt[hid_idx] = 1'b0;
            ok_nxt              = 1'b1;
          end
        end
        FUNC_RESET_COUNTER: begin
          if (hid_hit) begin
            count_we = 1'b1;
            count_wa = hid_idx;
            count_wd = '0;
            ok_nxt   = 1'b1;
          end
        end
        FUNC_CHANGE_TIMEOUT: begin
          if (hid_hit) begin
            limit_we = 1'b1;
            limit_wa = hid_idx;
            limit_wd = limit_r;
            count_we = 1'b1;
            count_wa = hid_idx;
            count_wd = '0;
            ok_nxt   = 1'b1;
          end
        end
        FUNC_TICK: begin
          ok_nxt   = 1'b1;
          mask_nxt = fire_r;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  assign out_ok        = ok_r;
  assign out_id        = id_r;
  assign out_fire_mask = mask_r;

endmodule

`default_nettype wire

// File: test/tb_timeout_channel_table_unit.sv
`timescale 1ns / 1ps

module tb_timeout_channel_table_unit;
  import tct_pkg::*;

  localparam int NCH = DEF_NUM_CHANNELS;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [ID_W-1:0]    id;
    logic [LIMIT_W-1:0] limit;
    bit                 drain_first;
  } chan_op_t;

  typedef struct {
    logic              ok;
    logic [ID_W-1:0]   id;
    logic [FIRE_W-1:0] fire;
  } chan_resp_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  in_func;
  logic [KEY_W-1:0]   in_name_key;
  logic [ID_W-1:0]    in_handler_id;
  logic [LIMIT_W-1:0] in_timeout_value;
  logic               out_valid;
  logic               out_ok;
  logic [ID_W-1:0]    out_id;
  logic [FIRE_W-1:0]  out_fire_mask;

  timeout_channel_table_unit #(.NUM_CHANNELS(NCH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_name_key      (in_name_key),
    .in_handler_id    (in_handler_id),
    .in_timeout_value (in_timeout_value),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_id           (out_id),
    .out_fire_mask    (out_fire_mask)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  chan_op_t   op_q[$];
  chan_resp_t resp_q[$];
  logic [KEY_W-1:0] key_pool[24];
  bit  drain_next = 1'b0;
  bit  taken = 1'b0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_miss = 0;
  int  n_reg_ok = 0, n_dup = 0, n_full = 0, n_ticks = 0, n_fires = 0;
  int  n_bad_id = 0, n_unknown = 0;

  // predictor state
  bit                 slot_on[NCH];
  logic [KEY_W-1:0]   slot_key[NCH];
  logic [LIMIT_W-1:0] slot_lim[NCH];
  logic [LIMIT_W-1:0] slot_cnt[NCH];

  task automatic table_step(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                            input logic [ID_W-1:0] id, input logic [LIMIT_W-1:0] lim,
                            output chan_resp_t r);
    int  hit;
    bit  id_ok;
    hit = -1;
    id_ok = (id != 0) && (id <= NCH);
    if (id_ok)
      id_ok = slot_on[id - 1];
    r.ok = 1'b0;
    r.id = '0;
    r.fire = '0;
    case (f)
      FUNC_REGISTER: begin
        for (int i = 0; i < NCH; i++)
          if (hit < 0 && slot_on[i] && slot_key[i] == k) hit = i;
        if (hit >= 0) begin
          r.id = ID_W'(hit + 1);
          n_dup++;
        end else begin
          for (int i = 0; i < NCH; i++)
            if (hit < 0 && !slot_on[i]) hit = i;
          if (hit >= 0) begin
            slot_key[hit] = k;
            slot_lim[hit] = lim;
            slot_cnt[hit] = '0;
            slot_on[hit] = 1'b1;
            r.id = ID_W'(hit + 1);
            r.ok = 1'b1;
            n_reg_ok++;
          end else begin
            n_full++;
          end
        end
      end
      FUNC_UNREGISTER, FUNC_RESET_COUNTER, FUNC_CHANGE_TIMEOUT: begin
        if (!id_ok) begin
          n_bad_id++;
        end else begin
          r.ok = 1'b1;
          slot_cnt[id - 1] = '0;
          if (f == FUNC_UNREGISTER) begin
            slot_on[id - 1] = 1'b0;
            slot_key[id - 1] = '0;
            slot_lim[id - 1] = '0;
          end else if (f == FUNC_CHANGE_TIMEOUT) begin
            slot_lim[id - 1] = lim;
          end
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < NCH; i++) begin
          if (slot_on[i]) begin
            if (slot_cnt[i] >= slot_lim[i]) begin
              slot_cnt[i] = '0;
              if (i < FIRE_W) begin
                r.fire[i] = 1'b1;
                n_fires++;
              end
            end else begin
              slot_cnt[i] = slot_cnt[i] + 1;
            end
          end
        end
        r.ok = 1'b1;
        n_ticks++;
      end
      default: n_unknown++;
    endcase
  endtask

  task automatic queue_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                          input logic [ID_W-1:0] id, input logic [LIMIT_W-1:0] lim);
    chan_op_t w;
    w.func = f;
    w.key = k;
    w.id = id;
    w.limit = lim;
    w.drain_first = drain_next;
    drain_next = 1'b0;
    op_q.push_back(w);
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(7))
      0: return $urandom;
      1: return '0;
      default: return $urandom_range(5);
    endcase
  endfunction

  task automatic queue_random_op();
    int                 r;
    logic [ID_W-1:0]    id;
    logic [KEY_W-1:0]   k;
    r = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(31)) : ID_W'($urandom_range(NCH, 1));
    k = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(23)];
    if (r < 20)
      queue_op(FUNC_REGISTER, k, id, pick_limit());
    else if (r < 34)
      queue_op(FUNC_UNREGISTER, k, id, $urandom);
    else if (r < 46)
      queue_op(FUNC_RESET_COUNTER, k, id, $urandom);
    else if (r < 56)
      queue_op(FUNC_CHANGE_TIMEOUT, k, id, pick_limit());
    else if (r < 97)
      queue_op(FUNC_TICK, k, id, $urandom);
    else
      queue_op(FUNC_W'($urandom_range({FUNC_W{1'b1}}, FUNC_TICK + 1)), k, id, $urandom);
  endtask

  task automatic note_miss(input string field, input logic [31:0] want_v,
                           input logic [31:0] got_v);
    n_miss++;
    if (n_miss <= 10)
      $display("mismatch in %s on result %0d: expected %0h, got %0h",
               field, n_checked, want_v, got_v);
  endtask

  // driver
  always @(negedge clk) begin : drive
    chan_op_t w;
    bit       go;
    bit       quiet;
    if (rst_n && !(start && !taken)) begin
      go = 1'b0;
      quiet = (n_sent >= 700) && (n_sent < 1000);
      if (op_q.size() != 0 && (quiet || $urandom_range(99) >= 9))
        go = !(op_q[0].drain_first && (resp_q.size() != 0 || busy));
      if (go) begin
        w = op_q.pop_front();
        in_func <= w.func;
        in_name_key <= w.key;
        in_handler_id <= w.id;
        in_timeout_value <= w.limit;
        n_sent++;
      end
      start <= go;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : watch
    chan_resp_t want;
    chan_resp_t next_want;
    if (rst_n) begin
      if (out_valid) begin
        if (resp_q.size() == 0) begin
          n_miss++;
          if (n_miss <= 10)
            $display("unexpected result: ok %0b id %0d fire %0h",
                     out_ok, out_id, out_fire_mask);
        end else begin
          want = resp_q.pop_front();
          if (out_ok !== want.ok) note_miss("ok", want.ok, out_ok);
          if (out_id !== want.id) note_miss("out_id", want.id, out_id);
          if (out_fire_mask !== want.fire) note_miss("fire_mask", want.fire, out_fire_mask);
          n_checked++;
        end
      end
      if (start && !busy) begin
        table_step(in_func, in_name_key, in_handler_id, in_timeout_value, next_want);
        resp_q.push_back(next_want);
      end
    end
    taken <= rst_n && start && !busy;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = '0;
    in_name_key = '0;
    in_handler_id = '0;
    in_timeout_value = '0;
    for (int i = 0; i < NCH; i++) begin
      slot_on[i] = 1'b0;
      slot_key[i] = '0;
      slot_lim[i] = '0;
      slot_cnt[i] = '0;
    end
    for (int i = 0; i < 24; i++)
      key_pool[i] = $urandom;

    queue_op(FUNC_TICK, '0, '0, '0);
    queue_op(FUNC_UNREGISTER, '1, '0, '1);
    queue_op(FUNC_RESET_COUNTER, '0, 5'd5, '0);
    queue_op(FUNC_REGISTER, '0, '0, '0);
    queue_op(FUNC_REGISTER, '1, '1, '1);
    queue_op(FUNC_REGISTER, '0, '0, 32'd7);
    queue_op(FUNC_REGISTER, 32'hA5A5_5A5A, '0, 32'd1);
    queue_op(FUNC_TICK, '0, '0, '0);
    queue_op(FUNC_TICK, '0, '0, '0);
    queue_op(FUNC_TICK, '0, '0, '0);
    queue_op(FUNC_RESET_COUNTER, '0, 5'd3, '0);
    queue_op(FUNC_CHANGE_TIMEOUT, '0, 5'd2, '0);
    queue_op(FUNC_CHANGE_TIMEOUT, '0, '0, 32'd3);
    queue_op(FUNC_CHANGE_TIMEOUT, '0, 5'd17, 32'd3);
    queue_op(FUNC_RESET_COUNTER, '0, '1, '0);
    queue_op(FUNC_UNREGISTER, '0, 5'd16, '0);
    queue_op(FUNC_TICK, '0, '0, '0);
    queue_op(FUNC_UNREGISTER, '0, 5'd1, '0);
    queue_op(FUNC_UNREGISTER, '0, 5'd1, '0);
    queue_op(FUNC_REGISTER, 32'h1234_5678, '0, 32'd2);
    queue_op(FUNC_W'(5), '0, '0, '0);
    queue_op(FUNC_W'(6), '0, '0, '0);
    queue_op(FUNC_W'(7), '1, '1, '1);
    queue_op(FUNC_TICK, '0, '0, '0);

    // fill the table past full
    drain_next = 1'b1;
    for (int i = 0; i < NCH + 2; i++)
      queue_op(FUNC_REGISTER, $urandom, ID_W'($urandom_range(31)), pick_limit());
    for (int ph = 0; ph < 3; ph++) begin
      drain_next = 1'b1;
      for (int i = 0; i < 536; i++)
        queue_random_op();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (op_q.size() != 0 || resp_q.size() != 0 || start)
      @(posedge clk);
    repeat (NCH + 10) @(posedge clk);

    $display("checked %0d results: %0d registrations, %0d duplicate keys, %0d table full",
             n_checked, n_reg_ok, n_dup, n_full);
    $display("%0d ticks with %0d channel fires, %0d bad ids, %0d unknown ops",
             n_ticks, n_fires, n_bad_id, n_unknown);
    if (n_miss == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
